### hw/rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types, codes and defaults for the soft timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int DEF_NUM_TIMERS = 8;
    localparam int DEF_TICK_WIDTH = 32;

    // Operation codes carried by the mode field.
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_SET     = 3'd1;
    localparam logic [2:0] MODE_START   = 3'd2;
    localparam logic [2:0] MODE_STOP    = 3'd3;
    localparam logic [2:0] MODE_RELEASE = 3'd4;

    typedef enum logic [1:0] {
        ST_NOT_USED = 2'd0,
        ST_STOPPED  = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_ABORTED  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OP_RD,
        S_EXEC,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture_in;
        logic tick_inc;
        logic scan_clr;
        logic scan_inc;
        logic rd_scan;
        logic rd_op;
        logic scan_chk;
        logic exec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic scan_last;
    } t_dp_stat;

endpackage

### hw/rtl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// Sequencer for the timer bank: decodes each beat, walks the timers on a
// tick, then reads, updates and reports the addressed timer.
// ----------------------------------------------------------------------------
module stb_ctrl
    import stb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output logic     busy,
    output logic     o_done,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = i_stat.is_tick ? S_SCAN_RD : S_EXEC;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_state = i_stat.scan_last ? S_OP_RD : S_SCAN_RD;
            end
            S_OP_RD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy             = 1'b0;
                o_cmd.capture_in = start;
            end
            S_DECODE: begin
                if (i_stat.is_tick) begin
                    o_cmd.tick_inc = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                end else begin
                    o_cmd.rd_op = 1'b1;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                o_cmd.scan_inc = 1'b1;
            end
            S_OP_RD: begin
                o_cmd.rd_op = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### hw/rtl/stb_datapath.sv
// ----------------------------------------------------------------------------
// stb_datapath
// Tick counter, per-timer status flops, compare and duration RAMs, and the
// result registers of the timer bank.
// ----------------------------------------------------------------------------
module stb_datapath
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_timer_index,
    input  logic [31:0] i_count_value,
    output t_dp_stat    o_stat,
    output logic [1:0]  o_status,
    output logic [31:0] o_remaining,
    output logic        o_stop_fired,
    output logic [7:0]  o_expired_mask,
    output logic        o_timeout_flag
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [2:0]            r_mode;
    logic [2:0]            r_idx;
    logic [31:0]           r_cnt;
    logic [TICK_WIDTH-1:0] r_now;
    t_status               r_tstate [NUM_TIMERS];
    logic [AW-1:0]         r_scan;
    logic [AW-1:0]         r_addr;
    logic [7:0]            r_mask;
    logic                  r_tflag;
    t_status               r_status;
    logic [31:0]           r_rem;
    logic                  r_fired;

    logic [6:0]            idx_ext;
    logic [6:0]            addr_ext;
    logic [AW-1:0]         idx_addr;
    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic                  idx_valid;
    logic [TICK_WIDTH-1:0] cmp_rd;
    logic [TICK_WIDTH-1:0] dur_rd;
    logic [TICK_WIDTH-1:0] cnt_tw;
    logic [TICK_WIDTH-1:0] dur_wdata;
    t_status               cur_st;
    logic [TICK_WIDTH-1:0] cmp_eff;
    logic [TICK_WIDTH-1:0] dur_eff;
    t_status               new_st;
    logic [TICK_WIDTH-1:0] new_cmp;
    logic [TICK_WIDTH-1:0] rem_tw;
    logic                  fired;
    logic                  cmp_we;
    logic                  dur_we;

    assign idx_ext   = {4'b0000, r_idx};
    assign addr_ext  = 7'(r_addr);
    assign idx_addr  = idx_ext[AW-1:0];
    assign idx_valid = idx_ext < 7'(NUM_TIMERS);
    assign rd_addr   = i_cmd.rd_scan ? r_scan : idx_addr;
    assign rd_en     = i_cmd.rd_scan | i_cmd.rd_op;
    assign cnt_tw    = TICK_WIDTH'(r_cnt);

    assign o_stat.is_tick   = (r_mode == MODE_TICK);
    assign o_stat.scan_last = (r_scan == AW'(NUM_TIMERS - 1));

    // A timer that is not used always reads as zero compare and duration, so
    // its RAM words need no clearing and are masked here instead.
    assign cur_st  = r_tstate[r_addr];
    assign cmp_eff = (cur_st == ST_NOT_USED) ? '0 : cmp_rd;
    assign dur_eff = (cur_st == ST_NOT_USED) ? '0 : dur_rd;

    always_comb begin
        new_st  = cur_st;
        new_cmp = cmp_eff;
        fired   = 1'b0;
        rem_tw  = cmp_eff - r_now;
        unique case (r_mode)
            MODE_SET: begin
                new_st  = ST_STOPPED;
                new_cmp = '0;
                rem_tw  = '0 - r_now;
            end
            MODE_START: begin
                new_st  = ST_RUNNING;
                new_cmp = dur_eff + r_now;
                rem_tw  = dur_eff;
            end
            MODE_STOP: begin
                if (cur_st == ST_RUNNING) begin
                    if (cmp_eff <= r_now) begin
                        new_st = ST_STOPPED;
                        fired  = 1'b1;
                    end else begin
                        new_st = ST_ABORTED;
                    end
                end
            end
            MODE_RELEASE: begin
                new_st  = ST_NOT_USED;
                new_cmp = '0;
                rem_tw  = '0 - r_now;
            end
            default: begin
                new_st = cur_st;
            end
        endcase
    end

    // Any command other than set count on a timer that is not used writes its
    // duration word to zero, so a timer started straight from not used and
    // restarted later reads a zero duration instead of a stale or unwritten word.
    assign cmp_we    = i_cmd.exec & idx_valid & ((r_mode == MODE_SET) | (r_mode == MODE_START));
    assign dur_we    = i_cmd.exec & idx_valid & ((r_mode == MODE_SET) | (cur_st == ST_NOT_USED));
    assign dur_wdata = (r_mode == MODE_SET) ? cnt_tw : '0;

    stb_ram #(
        .WIDTH (TICK_WIDTH),
        .DEPTH (NUM_TIMERS)
    ) u_cmp_ram (
        .i_clk   (i_clk),
        .i_we    (cmp_we),
        .i_waddr (r_addr),
        .i_wdata (new_cmp),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (cmp_rd)
    );

    stb_ram #(
        .WIDTH (TICK_WIDTH),
        .DEPTH (NUM_TIMERS)
    ) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (dur_we),
        .i_waddr (r_addr),
        .i_wdata (dur_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (dur_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_in) begin
            r_mode <= i_mode;
            r_idx  <= i_timer_index;
            r_cnt  <= i_count_value;
        end
        if (rd_en) begin
            r_addr <= rd_addr;
        end
        if (i_cmd.exec) begin
            r_status <= idx_valid ? new_st : ST_NOT_USED;
            r_rem    <= idx_valid ? 32'(rem_tw) : 32'd0;
            r_fired  <= idx_valid & fired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_scan  <= '0;
            r_mask  <= '0;
            r_tflag <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_tstate[i] <= ST_NOT_USED;
            end
        end else begin
            if (i_cmd.capture_in) begin
                r_mask  <= '0;
                r_tflag <= 1'b0;
            end
            if (i_cmd.tick_inc) begin
                r_now <= r_now + 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.scan_chk && cur_st == ST_RUNNING && cmp_rd <= r_now) begin
                r_tstate[r_addr] <= ST_STOPPED;
                r_tflag          <= 1'b1;
                if (addr_ext < 7'd8) begin
                    r_mask[addr_ext[2:0]] <= 1'b1;
                end
            end
            if (i_cmd.exec && idx_valid) begin
                r_tstate[r_addr] <= new_st;
            end
        end
    end

    assign o_status       = r_status;
    assign o_remaining    = r_rem;
    assign o_stop_fired   = r_fired;
    assign o_expired_mask = r_mask;
    assign o_timeout_flag = r_tflag;

endmodule

### hw/rtl/soft_timer_bank.sv
// ----------------------------------------------------------------------------
// soft_timer_bank
// A bank of one-shot timers that share one tick counter, advanced by tick commands.
// ----------------------------------------------------------------------------
// Usage. A command beat is taken at a rising edge where start is high and
// busy is low; it carries i_mode (tick, set count, start, stop, release),
// i_timer_index and i_count_value. Busy stays high until the beat is done.
// Every beat yields exactly one result, shown on o_status, o_remaining,
// o_stop_fired, o_expired_mask and o_timeout_flag for the single cycle in
// which o_done is high. The receiver cannot hold results off, so nothing
// ever stalls on the output side.
// Sequence. A timer command passes through the decode, execute and done
// states after acceptance, with o_done high in the done state. A tick
// walks the timers one at a time, with a read state and a check state for
// each because the compare RAM has a registered read, before it reads back
// the addressed timer.
// Reset. The synchronous, active-low reset clears the tick counter and sets
// every timer to not used. The compare and duration RAMs are not cleared:
// a timer that is not used reads as zero compare and zero duration, so no
// clearing pass is needed and the bank takes commands right after reset.
// ----------------------------------------------------------------------------
module soft_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_timer_index,
    input  logic [31:0] i_count_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_remaining,
    output logic        o_stop_fired,
    output logic [7:0]  o_expired_mask,
    output logic        o_timeout_flag
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller only sequences; all timer state lives in the datapath.
    stb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_mode         (i_mode),
        .i_timer_index  (i_timer_index),
        .i_count_value  (i_count_value),
        .o_stat         (dp_stat),
        .o_status       (o_status),
        .o_remaining    (o_remaining),
        .o_stop_fired   (o_stop_fired),
        .o_expired_mask (o_expired_mask),
        .o_timeout_flag (o_timeout_flag)
    );

    // An accepted beat keeps the bank busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("bank not busy after accepting a beat");

    // Results are single-cycle strobes; two in a row would mean a lost beat.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // A result is only shown while the bank is still busy with that beat.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // An expiry bit without the timeout flag means the tick walk slipped.
    a_mask_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_timeout_flag) |-> (o_expired_mask == 8'd0))
        else $error("expired mask set without timeout flag");

    // A fired stop always leaves the timer stopped.
    a_fired_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_stop_fired) |-> (o_status == ST_STOPPED))
        else $error("fired stop with wrong status");

endmodule
